@@ rtl/mtep_pkg.sv @@
// package for the midi track event parser: phases, sequencer states, result kinds, status and duration constants
// no dependencies
`timescale 1ns / 1ps
package mtep_pkg;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_MTYPE  = 3'd2,
    PH_LEN    = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DATA1  = 3'd5,
    PH_DATA2  = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    SQ_IDLE   = 3'd0,
    SQ_SEARCH = 3'd1,
    SQ_DUR    = 3'd2,
    SQ_SHIFT  = 3'd3,
    SQ_FLUSH  = 3'd4,
    SQ_EMIT   = 3'd5
  } seq_e;

  localparam logic [1:0] KIND_NOTE  = 2'd0;
  localparam logic [1:0] KIND_TEMPO = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_BADLEN = 2'd3;

  localparam logic [7:0] ST_META  = 8'hFF;
  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] ST_ESC   = 8'hF7;
  localparam logic [7:0] META_TEMPO = 8'h51;

  localparam logic [2:0] DUR_QUARTER = 3'd2;
  localparam logic [2:0] DUR_LAST    = 3'd5;

endpackage

@@ rtl/mtep_if.sv @@
// valid/ready channel interface carrying one word of payload
// depends on nothing
`timescale 1ns / 1ps
interface mtep_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mtep_ram.sv @@
// generic ram with one write port and one read port, registered read
// no dependencies
`timescale 1ns / 1ps
module mtep_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/midi_track_event_parser.sv @@
// top level of the midi track event parser: byte parser, pending note table, sequencer
// depends on mtep_pkg, mtep_if, mtep_ram
`timescale 1ns / 1ps
// One track byte (or an end-of-track marker) is taken per input word. A note-off
// walks the pending table one entry at a time through the table ram (address then
// compare), then runs the duration class compare for classes 0 to 4 in turn on one
// shared compare unit, then compacts the table one entry at a time (read then write).
// An end of track flushes the pending notes, one result word per note. The block
// takes no word while a word is being worked or a result waits to be taken.
module midi_track_event_parser
  import mtep_pkg::*;
#(
  parameter int PENDING_DEPTH = 16,
  parameter int TICK_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  mtep_if.sink   in_if,
  mtep_if.source out_if
);
  localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int EW = 7 + 7 + 4 + TICK_BITS;

  // pending entry layout: pitch, velocity, channel, start
  typedef struct packed {
    logic [6:0]           pitch;
    logic [6:0]           vel;
    logic [3:0]           ch;
    logic [TICK_BITS-1:0] start;
  } pend_t;

  logic [15:0] tpq_q;
  phase_e      ph_q, ph_d;
  seq_e        sq_q, sq_d;
  logic [7:0]  rs_q, rs_d;
  logic [TICK_BITS-1:0] tick_q, tick_d;
  logic [31:0] vlq_q, vlq_d;
  logic [2:0]  vbytes_q, vbytes_d;
  logic [7:0]  mkind_q, mkind_d;
  logic [31:0] mrem_q, mrem_d;
  logic [23:0] tempo_q, tempo_d;
  logic [6:0]  fd_q, fd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        halt_q, halt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [2:0]  k_q, k_d;
  logic [TICK_BITS-1:0] dur_q, dur_d;
  logic        rd_ph_q, rd_ph_d;  // ram read in flight
  pend_t       hit_q, hit_d;

  // output word register
  logic        ov_q, ov_d;
  logic [1:0]  okind_q, okind_d;
  logic [6:0]  opitch_q, opitch_d, ovel_q, ovel_d;
  logic [3:0]  och_q, och_d;
  logic [31:0] ostart_q, ostart_d;
  logic [2:0]  odur_q, odur_d;
  logic [23:0] otempo_q, otempo_d;
  logic        oflush_q, oflush_d, olast_q, olast_d;
  seq_e        after_q, after_d;  // where to go once the output word is taken

  // table ram
  logic          we;
  logic [IW-1:0] waddr, raddr;
  pend_t         wdata, rdata;
  logic [EW-1:0] rdata_raw;

  mtep_ram #(.Width(EW), .Depth(PENDING_DEPTH)) u_tab (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata_raw)
  );
  assign rdata = pend_t'(rdata_raw);

  assign in_if.ready = (sq_q == SQ_IDLE) && !ov_q;
  wire acc = in_if.valid && in_if.ready;
  wire mode = in_if.data.mode;
  wire [7:0] b = in_if.data.data_byte;
  wire [3:0] hi = rs_q[7:4];
  wire is_chan = hi >= 4'h8 && hi <= 4'hE;

  // shared duration compare: 2^(k+1)*d >= 7*tpq
  wire [TICK_BITS+22:0] lhs = {{23{1'b0}}, dur_q} << (k_q + 3'd1);
  wire [TICK_BITS+22:0] rhs = (TICK_BITS + 23)'(tpq_q) * (TICK_BITS + 23)'(7);
  wire dur_ge = lhs >= rhs;

  assign out_if.valid = ov_q;
  assign out_if.data.kind = okind_q;
  assign out_if.data.pitch = opitch_q;
  assign out_if.data.velocity = ovel_q;
  assign out_if.data.channel = och_q;
  assign out_if.data.start_tick = ostart_q;
  assign out_if.data.duration_class = odur_q;
  assign out_if.data.tempo_us = otempo_q;
  assign out_if.data.from_flush = oflush_q;
  assign out_if.data.last = olast_q;

  function automatic logic [31:0] tk32(input logic [TICK_BITS-1:0] t);
    logic [63:0] w;
    begin
      w = 64'(t);
      return w[31:0];
    end
  endfunction

  always_comb begin
    logic       fin, vlq_more;
    logic [31:0] nv;
    logic [2:0]  nb;
    phase_e      ph;
    ph_d = ph_q; sq_d = sq_q; rs_d = rs_q; tick_d = tick_q; vlq_d = vlq_q;
    vbytes_d = vbytes_q; mkind_d = mkind_q; mrem_d = mrem_q; tempo_d = tempo_q;
    fd_d = fd_q; cnt_d = cnt_q; halt_d = halt_q; idx_d = idx_q; k_d = k_q;
    dur_d = dur_q; rd_ph_d = rd_ph_q; hit_d = hit_q;
    ov_d = ov_q; okind_d = okind_q; opitch_d = opitch_q; ovel_d = ovel_q;
    och_d = och_q; ostart_d = ostart_q; odur_d = odur_q; otempo_d = otempo_q;
    oflush_d = oflush_q; olast_d = olast_q; after_d = after_q;
    we = 1'b0; waddr = idx_q; raddr = idx_q; wdata = hit_q;
    fin = 1'b0; vlq_more = 1'b0; nv = '0; nb = '0; ph = ph_q;

    if (ov_q && out_if.ready) begin
      ov_d = 1'b0;
      sq_d = after_q;
    end

    unique case (sq_q)
      SQ_IDLE: begin
        if (acc) begin
          // clear the result word fields
          okind_d = KIND_NOTE; opitch_d = '0; ovel_d = '0; och_d = '0;
          ostart_d = '0; odur_d = '0; otempo_d = '0; oflush_d = 1'b0;
          olast_d = 1'b1; after_d = SQ_IDLE;
          if (mode) begin
            idx_d = '0; rd_ph_d = 1'b0;
            if (cnt_q != '0) sq_d = SQ_FLUSH;
            ph_d = PH_DELTA; vlq_d = '0; vbytes_d = '0; rs_d = '0; tick_d = '0;
            mkind_d = '0; mrem_d = '0; tempo_d = '0; fd_d = '0; halt_d = 1'b0;
          end else if (!halt_q) begin
            // resolve the status phase redirect first (data byte under running status)
            if (ph_q == PH_STATUS && !b[7]) begin
              if (rs_q == ST_META) begin
                ph = PH_MTYPE;
              end else if (rs_q == ST_SYSEX || rs_q == ST_ESC) begin
                mkind_d = rs_q; ph = PH_LEN; vlq_d = '0; vbytes_d = '0;
              end else if (is_chan) begin
                ph = PH_DATA1;
              end else begin
                ph = PH_DELTA; vlq_d = '0; vbytes_d = '0;
              end
            end
            nv = {vlq_d[24:0], b[6:0]};
            nb = vbytes_d + 3'd1;
            fin = !b[7];
            vlq_more = b[7] && nb < 3'd4;
            unique case (ph)
              PH_DELTA: begin
                if (fin) begin
                  tick_d = tick_q + TICK_BITS'(nv);
                  ph_d = PH_STATUS; vlq_d = '0; vbytes_d = '0;
                end else if (vlq_more) begin
                  vlq_d = nv; vbytes_d = nb;
                end else begin
                  halt_d = 1'b1; okind_d = KIND_BADLEN; ov_d = 1'b1;
                end
              end
              PH_STATUS: begin
                rs_d = b; vlq_d = '0; vbytes_d = '0;
                if (b == ST_META) ph_d = PH_MTYPE;
                else if (b == ST_SYSEX || b == ST_ESC) begin
                  mkind_d = b; ph_d = PH_LEN;
                end else if (b[7:4] >= 4'h8 && b[7:4] <= 4'hE) ph_d = PH_DATA1;
                else ph_d = PH_DELTA;
              end
              PH_MTYPE: begin
                mkind_d = b; ph_d = PH_LEN; vlq_d = '0; vbytes_d = '0;
              end
              PH_LEN: begin
                if (fin) begin
                  mrem_d = nv; tempo_d = '0; vlq_d = '0;
                  if (nv == '0) begin
                    ph_d = PH_DELTA; vbytes_d = '0;
                  end else begin
                    ph_d = PH_SKIP;
                    vbytes_d = (mkind_d == META_TEMPO && nv >= 32'd3) ? 3'd0 : 3'd3;
                  end
                end else if (vlq_more) begin
                  vlq_d = nv; vbytes_d = nb; ph_d = PH_LEN;
                end else begin
                  halt_d = 1'b1; okind_d = KIND_BADLEN; ov_d = 1'b1; ph_d = PH_LEN;
                end
              end
              PH_SKIP: begin
                if (vbytes_q < 3'd3) begin
                  tempo_d = {tempo_q[15:0], b};
                  vbytes_d = vbytes_q + 3'd1;
                  if (vbytes_q == 3'd2) begin
                    okind_d = KIND_TEMPO; otempo_d = {tempo_q[15:0], b}; ov_d = 1'b1;
                  end
                end
                mrem_d = mrem_q - 32'd1;
                if (mrem_q == 32'd1) begin
                  ph_d = PH_DELTA; vlq_d = '0; vbytes_d = '0;
                end
              end
              PH_DATA1: begin
                if (hi == 4'hC || hi == 4'hD) begin
                  ph_d = PH_DELTA; vlq_d = '0; vbytes_d = '0;
                end else begin
                  fd_d = b[6:0]; ph_d = PH_DATA2;
                end
              end
              PH_DATA2: begin
                ph_d = PH_DELTA; vlq_d = '0; vbytes_d = '0;
                if (hi == 4'h9 && b != 8'h00) begin
                  if (cnt_q >= CW'(PENDING_DEPTH)) begin
                    okind_d = KIND_FULL; opitch_d = fd_q; ovel_d = b[6:0];
                    och_d = rs_q[3:0]; ostart_d = tk32(tick_q); ov_d = 1'b1;
                  end else begin
                    we = 1'b1; waddr = IW'(cnt_q);
                    wdata = '{pitch: fd_q, vel: b[6:0], ch: rs_q[3:0], start: tick_q};
                    cnt_d = cnt_q + CW'(1);
                  end
                end else if ((hi == 4'h9 || hi == 4'h8) && cnt_q != '0) begin
                  idx_d = '0; rd_ph_d = 1'b0; sq_d = SQ_SEARCH;
                end
              end
              default: begin
                ph_d = PH_DELTA; vlq_d = '0; vbytes_d = '0;
              end
            endcase
          end
        end
      end
      SQ_SEARCH: begin
        raddr = idx_q;
        if (!rd_ph_q) rd_ph_d = 1'b1;
        else begin
          rd_ph_d = 1'b0;
          if (rdata.pitch == fd_q && rdata.ch == rs_q[3:0]) begin
            hit_d = rdata; dur_d = tick_q - rdata.start; k_d = '0;
            sq_d = SQ_DUR;
          end else if (CW'(idx_q) + CW'(1) >= cnt_q) sq_d = SQ_IDLE;
          else idx_d = idx_q + IW'(1);
        end
      end
      SQ_DUR: begin
        // one compare per cycle, class k from 0 to 4
        if (tpq_q == '0 || dur_ge || k_q == 3'd4) begin
          odur_d = (tpq_q == '0) ? DUR_QUARTER : (dur_ge ? k_q : DUR_LAST);
          okind_d = KIND_NOTE; opitch_d = hit_q.pitch; ovel_d = hit_q.vel;
          och_d = hit_q.ch; ostart_d = tk32(hit_q.start); rd_ph_d = 1'b0;
          sq_d = SQ_SHIFT;
        end else k_d = k_q + 3'd1;
      end
      SQ_SHIFT: begin
        // move entries above the hit down by one, then emit
        if (CW'(idx_q) + CW'(1) >= cnt_q) begin
          cnt_d = cnt_q - CW'(1); ov_d = 1'b1; after_d = SQ_IDLE; sq_d = SQ_EMIT;
        end else begin
          raddr = idx_q + IW'(1);
          if (!rd_ph_q) rd_ph_d = 1'b1;
          else begin
            rd_ph_d = 1'b0; we = 1'b1; waddr = idx_q; wdata = rdata;
            idx_d = idx_q + IW'(1);
          end
        end
      end
      SQ_FLUSH: begin
        raddr = idx_q;
        if (!rd_ph_q) rd_ph_d = 1'b1;
        else begin
          rd_ph_d = 1'b0;
          okind_d = KIND_NOTE; opitch_d = rdata.pitch; ovel_d = rdata.vel;
          och_d = rdata.ch; ostart_d = tk32(rdata.start); odur_d = DUR_QUARTER;
          oflush_d = 1'b1; otempo_d = '0; ov_d = 1'b1; sq_d = SQ_EMIT;
          if (CW'(idx_q) + CW'(1) >= cnt_q) begin
            olast_d = 1'b1; after_d = SQ_IDLE; cnt_d = '0;
          end else begin
            olast_d = 1'b0; after_d = SQ_FLUSH; idx_d = idx_q + IW'(1);
          end
        end
      end
      SQ_EMIT: ;
      default: sq_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpq_q <= 16'd480;
      ph_q <= PH_DELTA; sq_q <= SQ_IDLE; rs_q <= '0; tick_q <= '0; vlq_q <= '0;
      vbytes_q <= '0; mkind_q <= '0; mrem_q <= '0; tempo_q <= '0; fd_q <= '0;
      cnt_q <= '0; halt_q <= 1'b0; idx_q <= '0; k_q <= '0; rd_ph_q <= 1'b0;
      ov_q <= 1'b0; after_q <= SQ_IDLE;
    end else begin
      if (cfg_we_i) tpq_q <= cfg_wdata_i;
      ph_q <= ph_d; sq_q <= sq_d; rs_q <= rs_d; tick_q <= tick_d; vlq_q <= vlq_d;
      vbytes_q <= vbytes_d; mkind_q <= mkind_d; mrem_q <= mrem_d; tempo_q <= tempo_d;
      fd_q <= fd_d; cnt_q <= cnt_d; halt_q <= halt_d; idx_q <= idx_d; k_q <= k_d;
      rd_ph_q <= rd_ph_d; ov_q <= ov_d; after_q <= after_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dur_q <= dur_d; hit_q <= hit_d;
    okind_q <= okind_d; opitch_q <= opitch_d; ovel_q <= ovel_d; och_q <= och_d;
    ostart_q <= ostart_d; odur_q <= odur_d; otempo_q <= otempo_d;
    oflush_q <= oflush_d; olast_q <= olast_d;
  end
endmodule

@@ dv/mtep_tb_types.sv @@
// payload types for the parser testbench channels: input word and result word
// depends on nothing; field order follows the block's word layout, first field on top
`timescale 1ns / 1ps
package mtep_tb_types;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [3:0]  channel;
    logic [31:0] start_tick;
    logic [2:0]  duration_class;
    logic [23:0] tempo_us;
    logic        from_flush;
    logic        last;
  } out_word_t;

endpackage

@@ dv/midi_track_event_parser_tb.sv @@
// testbench for midi_track_event_parser: random and directed track bytes, event prediction
// depends on mtep_pkg, mtep_if, mtep_tb_types and the parser rtl
`timescale 1ns / 1ps
module midi_track_event_parser_tb;
  import mtep_pkg::*;
  import mtep_tb_types::*;

  localparam int DEPTH = 16;

  // predicts the events of the parser and holds the ones not yet seen
  class midi_event_predictor;
    logic [15:0] tpq;
    phase_e      phase;
    logic [7:0]  run_st;
    logic [31:0] tick;
    logic [31:0] vlq_val;
    int          vlq_cnt;
    logic [7:0]  meta_k;
    logic [31:0] meta_left;
    logic [23:0] tempo_acc;
    logic [6:0]  data1;
    logic [6:0]  pn_pitch[DEPTH];
    logic [6:0]  pn_vel[DEPTH];
    logic [3:0]  pn_ch[DEPTH];
    logic [31:0] pn_start[DEPTH];
    int          pn_count;
    bit          halted;
    out_word_t   expected_events[$];
    out_word_t   step_events[$];
    int          notes_seen, tempos_seen, drops_seen, errors_seen;

    function new();
      tpq = 16'd480;
      clear();
    endfunction

    function void clear();
      phase = PH_DELTA; vlq_val = 0; vlq_cnt = 0;
      run_st = 0; tick = 0; meta_k = 0; meta_left = 0; tempo_acc = 0;
      data1 = 0; pn_count = 0; halted = 0;
    endfunction

    function void goto(phase_e p);
      phase = p; vlq_val = 0; vlq_cnt = 0;
    endfunction

    // 0 more bytes, 1 done, 2 too long
    function int vlq_add(logic [7:0] b);
      vlq_val = (vlq_val << 7) | {25'd0, b[6:0]};
      vlq_cnt++;
      if (!b[7]) return 1;
      if (vlq_cnt >= 4) return 2;
      return 0;
    endfunction

    function logic [2:0] dur_of(logic [31:0] d);
      logic [63:0] lim;
      logic [63:0] rnd;
      lim = 64'd7 * tpq;
      if (tpq == 0) return DUR_QUARTER;
      for (int k = 0; k < 5; k++) begin
        rnd = (64'd1 << (k + 1)) - 1;
        if ({32'd0, d} >= ((lim + rnd) >> (k + 1))) return 3'(k);
      end
      return DUR_LAST;
    endfunction

    function void emit(logic [1:0] kd, logic [6:0] p, logic [6:0] v, logic [3:0] c,
                       logic [31:0] st, logic [2:0] dc, logic [23:0] tu, logic fl);
      out_word_t w;
      w = '{kd, p, v, c, st, dc, tu, fl, 1'b0};
      step_events.push_back(w);
    endfunction

    function void parse(logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] ch;
      bit again;
      int r;
      hi = run_st[7:4];
      ch = run_st[3:0];
      again = 1;
      while (again) begin
        again = 0;
        case (phase)
          PH_DELTA: begin
            r = vlq_add(b);
            if (r == 2) begin
              halted = 1;
              emit(KIND_BADLEN, 0, 0, 0, 0, 0, 0, 0);
            end else if (r == 1) begin
              tick = tick + vlq_val;
              goto(PH_STATUS);
            end
          end
          PH_STATUS: begin
            if (b[7]) begin
              run_st = b;
              if (b == ST_META) goto(PH_MTYPE);
              else if (b == ST_SYSEX || b == ST_ESC) begin
                meta_k = b; goto(PH_LEN);
              end else if (b[7:4] >= 4'h8 && b[7:4] <= 4'hE) goto(PH_DATA1);
              else goto(PH_DELTA);
            end else if (run_st == ST_META) begin
              meta_k = b; goto(PH_LEN);
            end else if (run_st == ST_SYSEX || run_st == ST_ESC) begin
              meta_k = run_st; goto(PH_LEN); again = 1;
            end else if (hi >= 4'h8 && hi <= 4'hE) begin
              phase = PH_DATA1; again = 1;
            end else begin
              goto(PH_DELTA); again = 1;
            end
          end
          PH_MTYPE: begin
            meta_k = b; goto(PH_LEN);
          end
          PH_LEN: begin
            r = vlq_add(b);
            if (r == 2) begin
              halted = 1;
              emit(KIND_BADLEN, 0, 0, 0, 0, 0, 0, 0);
            end else if (r == 1) begin
              meta_left = vlq_val;
              tempo_acc = 0;
              if (meta_left == 0) goto(PH_DELTA);
              else begin
                goto(PH_SKIP);
                // counts tempo bytes taken; 3 means none left to take
                vlq_cnt = (meta_k == META_TEMPO && meta_left >= 3) ? 0 : 3;
              end
            end
          end
          PH_SKIP: begin
            if (vlq_cnt < 3) begin
              tempo_acc = {tempo_acc[15:0], b};
              vlq_cnt++;
              if (vlq_cnt == 3) emit(KIND_TEMPO, 0, 0, 0, 0, 0, tempo_acc, 0);
            end
            meta_left--;
            if (meta_left == 0) goto(PH_DELTA);
          end
          PH_DATA1: begin
            if (hi == 4'hC || hi == 4'hD) goto(PH_DELTA);
            else begin
              data1 = b[6:0];
              phase = PH_DATA2;
            end
          end
          PH_DATA2: begin
            goto(PH_DELTA);
            if (hi == 4'h9 && b != 0) begin
              if (pn_count >= DEPTH) emit(KIND_FULL, data1, b[6:0], ch, tick, 0, 0, 0);
              else begin
                pn_pitch[pn_count] = data1;
                pn_vel[pn_count] = b[6:0];
                pn_ch[pn_count] = ch;
                pn_start[pn_count] = tick;
                pn_count++;
              end
            end else if (hi == 4'h9 || hi == 4'h8) begin
              for (int i = 0; i < pn_count; i++) begin
                if (pn_pitch[i] == data1 && pn_ch[i] == ch) begin
                  emit(KIND_NOTE, pn_pitch[i], pn_vel[i], pn_ch[i], pn_start[i],
                       dur_of(tick - pn_start[i]), 0, 0);
                  for (int j = i + 1; j < pn_count; j++) begin
                    pn_pitch[j-1] = pn_pitch[j]; pn_vel[j-1] = pn_vel[j];
                    pn_ch[j-1] = pn_ch[j]; pn_start[j-1] = pn_start[j];
                  end
                  pn_count--;
                  break;
                end
              end
            end
          end
          default: goto(PH_DELTA);
        endcase
      end
    endfunction

    // an accepted input word: work out what it must cause
    function void take_word(in_word_t w);
      step_events.delete();
      if (w.mode) begin
        for (int i = 0; i < pn_count; i++)
          emit(KIND_NOTE, pn_pitch[i], pn_vel[i], pn_ch[i], pn_start[i], DUR_QUARTER, 0, 1);
        clear();
      end else if (!halted) begin
        parse(w.data_byte);
      end
      if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
      foreach (step_events[i]) begin
        case (step_events[i].kind)
          KIND_NOTE:  notes_seen++;
          KIND_TEMPO: tempos_seen++;
          KIND_FULL:  drops_seen++;
          default:    errors_seen++;
        endcase
        expected_events.push_back(step_events[i]);
      end
    endfunction

    // compare one result word against the oldest expected event
    function bit check_event(out_word_t got, output string msg);
      out_word_t e;
      msg = "";
      if (expected_events.size() == 0) begin
        msg = $sformatf("unexpected result %h", got);
        return 0;
      end
      e = expected_events.pop_front();
      if (got.kind != e.kind) msg = {msg, $sformatf(" kind %0d/%0d", got.kind, e.kind)};
      if (got.pitch != e.pitch) msg = {msg, $sformatf(" pitch %0d/%0d", got.pitch, e.pitch)};
      if (got.velocity != e.velocity)
        msg = {msg, $sformatf(" velocity %0d/%0d", got.velocity, e.velocity)};
      if (got.channel != e.channel)
        msg = {msg, $sformatf(" channel %0d/%0d", got.channel, e.channel)};
      if (got.start_tick != e.start_tick)
        msg = {msg, $sformatf(" start_tick %0d/%0d", got.start_tick, e.start_tick)};
      if (got.duration_class != e.duration_class)
        msg = {msg, $sformatf(" duration %0d/%0d", got.duration_class, e.duration_class)};
      if (got.tempo_us != e.tempo_us)
        msg = {msg, $sformatf(" tempo %0d/%0d", got.tempo_us, e.tempo_us)};
      if (got.from_flush != e.from_flush)
        msg = {msg, $sformatf(" from_flush %0d/%0d", got.from_flush, e.from_flush)};
      if (got.last != e.last) msg = {msg, $sformatf(" last %0d/%0d", got.last, e.last)};
      return msg == "";
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  mtep_if #(.payload_t(in_word_t))  in_ch ();
  mtep_if #(.payload_t(out_word_t)) out_ch ();

  midi_track_event_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  midi_event_predictor events = new();

  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int send_idle_pct = 0;     // sender idle chance per cycle
  int take_stall_pct = 0;    // receiver stall chance per cycle
  int hold_req = 0;          // bumped by the stimulus to ask for a long receiver hold
  int hold_seen = 0;
  int hold_left = 0;

  // 20 ns clock
  always begin
    clk_i = 1'b0; #10;
    clk_i = 1'b1; #10;
  end

  // generous overall limit
  initial begin
    #40ms;
    $display("midi_track_event_parser_tb: errors");
    $finish;
  end

  task automatic report(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // receiver: random stalls, plus a long hold counted here when asked for
  always @(posedge clk_i or negedge rst_ni) begin
    string msg;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (!events.check_event(out_ch.data, msg)) report(msg);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= take_stall_pct);
      end
    end
  end

  // one word to the parser; returns at the edge that accepted it
  task automatic send_word(logic m, logic [7:0] b);
    in_word_t w;
    w.mode = m;
    w.data_byte = b;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      // idle cycles, each one drawn on its own
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    events.take_word(w);
    words_sent++;
  endtask

  task automatic send_vlq(logic [31:0] v, int nb);
    for (int i = nb - 1; i >= 0; i--)
      send_word(1'b0, {(i != 0), 7'(v >> (7 * i))});
  endtask

  // wait for every expected event, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (events.expected_events.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_tpq(logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    events.tpq = v;
    cfg_we_i <= 1'b0;
  endtask

  // short random delta, now and then a long one
  task automatic rand_delta();
    int nb;
    logic [31:0] v;
    nb = ($urandom_range(9) == 0) ? $urandom_range(3, 2) : 1;
    v = (nb == 1) ? $urandom_range(127) : $urandom_range((1 << (7 * nb)) - 1);
    send_vlq(v, nb);
  endtask

  // status byte, or left out to ride on running status
  task automatic status(logic [7:0] s);
    if ($urandom_range(99) < 65) send_word(1'b0, s);
  endtask

  // one random track event with its delta
  task automatic rand_event();
    logic [3:0] ch;
    logic [7:0] pitch;
    int pick;
    int len;
    ch = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(1));
    pitch = ($urandom_range(4) == 0) ? 8'($urandom) : 8'(60 + $urandom_range(5));
    pick = $urandom_range(99);
    if (pick < 3) begin
      // noise byte, any value
      send_word(1'b0, 8'($urandom));
      return;
    end
    if (pick < 5) begin
      // end of track, data byte is don't care
      send_word(1'b1, 8'($urandom));
      return;
    end
    if (pick < 6) begin
      // over-long delta, parser halts until end of track
      repeat (4) send_word(1'b0, 8'hFF);
      send_word(1'b0, 8'($urandom));
      send_word(1'b1, 8'($urandom));
      return;
    end
    rand_delta();
    if (pick < 40) begin
      status({4'h9, ch});
      send_word(1'b0, pitch);
      send_word(1'b0, 8'($urandom_range(1, 255)));
    end else if (pick < 70) begin
      // note off, either form
      if ($urandom_range(1)) begin
        status({4'h8, ch});
        send_word(1'b0, pitch);
        send_word(1'b0, 8'($urandom));
      end else begin
        status({4'h9, ch});
        send_word(1'b0, pitch);
        send_word(1'b0, 8'h00);
      end
    end else if (pick < 77) begin
      send_word(1'b0, ST_META);
      send_word(1'b0, META_TEMPO);
      len = $urandom_range(4);
      send_vlq(len, 1);
      repeat (len) send_word(1'b0, 8'($urandom));
    end else if (pick < 81) begin
      send_word(1'b0, ST_META);
      send_word(1'b0, 8'($urandom_range(127)));
      len = $urandom_range(3);
      send_vlq(len, 1);
      repeat (len) send_word(1'b0, 8'($urandom));
    end else if (pick < 85) begin
      send_word(1'b0, $urandom_range(1) ? ST_SYSEX : ST_ESC);
      len = $urandom_range(3);
      send_vlq(len, ($urandom_range(3) == 0) ? 2 : 1);
      repeat (len) send_word(1'b0, 8'($urandom));
    end else if (pick < 92) begin
      // controller, poly pressure or pitch bend: two data bytes
      status({($urandom_range(2) == 0) ? 4'hA : ($urandom_range(1) ? 4'hB : 4'hE), ch});
      send_word(1'b0, 8'($urandom_range(127)));
      send_word(1'b0, 8'($urandom_range(127)));
    end else if (pick < 96) begin
      status({$urandom_range(1) ? 4'hC : 4'hD, ch});
      send_word(1'b0, 8'($urandom_range(127)));
    end else begin
      send_word(1'b0, 8'($urandom_range(8'hF1, 8'hFE)));
    end
  endtask

  // seventeen note-ons in a row overflow the pending table
  task automatic fill_table();
    for (int i = 0; i < DEPTH + 1; i++) begin
      send_vlq($urandom_range(20), 1);
      send_word(1'b0, 8'h90);
      send_word(1'b0, 8'(i));
      send_word(1'b0, 8'($urandom_range(1, 127)));
    end
  endtask

  task automatic rand_phase(int n);
    int stop;
    stop = words_sent + n;
    while (words_sent < stop) rand_event();
    send_word(1'b1, 8'h00);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: note on/off with running status and a two-byte delta
    send_vlq(0, 1); send_word(1'b0, 8'h90); send_word(1'b0, 8'h3C); send_word(1'b0, 8'h64);
    send_vlq(128, 2); send_word(1'b0, 8'h3C); send_word(1'b0, 8'h00);
    // set tempo 500000 us
    send_vlq(0, 1); send_word(1'b0, ST_META); send_word(1'b0, META_TEMPO);
    send_word(1'b0, 8'h03); send_word(1'b0, 8'h07); send_word(1'b0, 8'hA1);
    send_word(1'b0, 8'h20);
    // sysex skip, program change, lone system status
    send_vlq(0, 1); send_word(1'b0, ST_SYSEX); send_word(1'b0, 8'h01); send_word(1'b0, 8'hF7);
    send_vlq(0, 1); send_word(1'b0, 8'hC0); send_word(1'b0, 8'h05);
    send_vlq(0, 1); send_word(1'b0, 8'hF3);
    // pending note left for the flush, then an over-long delta and a halted byte
    send_vlq(0, 1); send_word(1'b0, 8'h9F); send_word(1'b0, 8'hFF); send_word(1'b0, 8'hFF);
    repeat (4) send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'hFF);
    send_word(1'b1, 8'hFF);
    drain();

    // phase 1: sender idles 27%, receiver 53%, tpq at its top
    write_tpq(16'hFFFF);
    send_idle_pct = 27; take_stall_pct = 53;
    fill_table();
    hold_req++;                // long receiver hold while the sender keeps going
    rand_phase(30);
    drain();                   // sender pause until every event is out
    rand_phase(30);
    drain();

    // phase 2: roles swapped, tpq zero makes every note a quarter, then tpq one
    write_tpq(16'h0000);
    send_idle_pct = 53; take_stall_pct = 27;
    rand_phase(30);
    drain();
    write_tpq(16'd1);
    fill_table();
    rand_phase(30);
    drain();

    // phase 3: no idling, common division
    write_tpq(16'd96);
    send_idle_pct = 0; take_stall_pct = 0;
    rand_phase(60);
    drain();

    $display("sent %0d words, checked %0d results", words_sent, results_seen);
    $display("notes %0d, tempos %0d, table drops %0d, length errors %0d",
             events.notes_seen, events.tempos_seen, events.drops_seen, events.errors_seen);
    if (mismatches == 0) begin
      $display("midi_track_event_parser_tb: clean");
    end else begin
      $display("midi_track_event_parser_tb: errors");
    end
    $finish;
  end

endmodule

@@ midi_track_event_parser.f @@
rtl/mtep_pkg.sv
rtl/mtep_if.sv
rtl/mtep_ram.sv
rtl/midi_track_event_parser.sv
dv/mtep_tb_types.sv
dv/midi_track_event_parser_tb.sv
